/* src/memory_pressure_defense_policy_defines.svh */
// Assertion macros shared by the checker of the memory pressure defense policy.
`ifndef MEMORY_PRESSURE_DEFENSE_POLICY_DEFINES_SVH
`define MEMORY_PRESSURE_DEFENSE_POLICY_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MPDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpdp assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MPDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpdp assertion failed");

`endif

/* src/mpdp_pkg.sv */
// Types, constants and helpers of the memory pressure defense policy.
package mpdp_pkg;

    localparam int unsigned PageW   = 31;
    localparam int unsigned WordW   = 32;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned DivCntW = $clog2(WordW);

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_OFF       = 2'd0;
    localparam t_mode MODE_AUTO_LOW  = 2'd1;
    localparam t_mode MODE_AUTO_HIGH = 2'd2;
    localparam t_mode MODE_FORCED    = 2'd3;

    localparam logic [CfgIdxW-1:0] CFG_THRESHOLD   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MANUAL_RATE = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_ENTRY_MODE  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_PACKET_MODE = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SECURE_MODE = 3'd4;

    localparam logic [WordW-1:0] THRESHOLD_RST   = 32'd1024;
    localparam logic [WordW-1:0] MANUAL_RATE_RST = 32'd10;

    typedef struct packed {
        logic [PageW-1:0] free_pages;
        logic [PageW-1:0] buffered_pages;
    } t_in_item;

    typedef struct packed {
        logic             drop_entries;
        logic [WordW-1:0] drop_rate;
        logic             load_drop_counter;
        t_mode            entry_mode_now;
        t_mode            packet_mode_now;
        t_mode            secure_mode_now;
        logic             timeout_change;
        logic             secure_timeouts;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_DONE
    } t_state;

    // Automatic modes follow the short-memory flag, others stay put.
    function automatic t_mode next_auto_mode(input t_mode mode, input logic short_mem);
        t_mode res;
        res = mode;
        if (mode == MODE_AUTO_LOW || mode == MODE_AUTO_HIGH) begin
            res = short_mem ? MODE_AUTO_HIGH : MODE_AUTO_LOW;
        end
        return res;
    endfunction

endpackage

/* src/memory_pressure_defense_policy.sv */
// Top level of the memory pressure defense policy block.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid / o_in_stall    | i_in_item (free, buffered pages)
//  out     | out       | o_out_valid / i_out_stall  | o_out_item (policy decisions)
//
// A result reaches the output register after its item passes the CALC and DONE
// states when no rate division is needed; when the automatic packet policy
// divides, the DIV state lies between them: the 32-bit quotient comes out of
// one restoring subtractor, one bit per cycle. The next item is accepted only
// once the sequencer is back in IDLE, after the result is in the output register.
// i_rst_n is synchronous, active low; it restores register defaults and modes.
// o_in_stall is high from acceptance until the result is in the output
// register; that register holds a result under i_out_stall while the next
// item is taken. Configuration writes are always ready.
module memory_pressure_defense_policy (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mpdp_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [mpdp_pkg::WordW-1:0]       i_cfg_data,
    // sample input
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  mpdp_pkg::t_in_item               i_in_item,
    // decision output
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output mpdp_pkg::t_out_item              o_out_item
);

    // sequencer
    mpdp_pkg::t_state r_state, n_state;

    // configuration; the mode settings live in the running mode registers,
    // since a write loads them directly
    logic [mpdp_pkg::WordW-1:0] r_threshold,   n_threshold;
    logic [mpdp_pkg::WordW-1:0] r_manual_rate, n_manual_rate;

    // policy state
    mpdp_pkg::t_mode r_entry_mode,  n_entry_mode;
    mpdp_pkg::t_mode r_packet_mode, n_packet_mode;
    mpdp_pkg::t_mode r_secure_mode, n_secure_mode;
    mpdp_pkg::t_mode r_prev_secure, n_prev_secure;

    // working registers of one item
    logic [mpdp_pkg::WordW-1:0]   r_avail, n_avail;
    mpdp_pkg::t_out_item          r_res,   n_res;

    // restoring divider: remainder, dividend/quotient shift, divisor
    logic [mpdp_pkg::WordW-1:0]   r_rem, n_rem;
    logic [mpdp_pkg::WordW-1:0]   r_quo, n_quo;
    logic [mpdp_pkg::WordW-1:0]   r_div, n_div;
    logic [mpdp_pkg::DivCntW-1:0] r_cnt, n_cnt;

    // output register
    logic                r_out_valid, n_out_valid;
    mpdp_pkg::t_out_item r_out_item,  n_out_item;

    // combinational helpers
    logic                       short_mem;
    logic [mpdp_pkg::WordW:0]   trial;
    logic [mpdp_pkg::WordW:0]   shifted;
    mpdp_pkg::t_mode            sec_next;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != mpdp_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign short_mem = (r_avail < r_threshold);
    // one divider step: shift in the next dividend bit, try the subtract
    assign shifted   = {r_rem, r_quo[mpdp_pkg::WordW-1]};
    assign trial     = shifted - {1'b0, r_div};
    assign sec_next  = mpdp_pkg::next_auto_mode(r_secure_mode, short_mem);

    always_comb begin
        n_state       = r_state;
        n_threshold   = r_threshold;
        n_manual_rate = r_manual_rate;
        n_entry_mode  = r_entry_mode;
        n_packet_mode = r_packet_mode;
        n_secure_mode = r_secure_mode;
        n_prev_secure = r_prev_secure;
        n_avail       = r_avail;
        n_res         = r_res;
        n_rem         = r_rem;
        n_quo         = r_quo;
        n_div         = r_div;
        n_cnt         = r_cnt;
        n_out_valid   = r_out_valid;
        n_out_item    = r_out_item;

        // output register drains when the consumer takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            mpdp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    // 31 + 31 bits never overflow 32
                    n_avail = {1'b0, i_in_item.free_pages}
                            + {1'b0, i_in_item.buffered_pages};
                    n_state = mpdp_pkg::ST_CALC;
                end
            end

            mpdp_pkg::ST_CALC: begin
                n_res = '0;

                // entry dropping
                case (r_entry_mode)
                    mpdp_pkg::MODE_FORCED: n_res.drop_entries = 1'b1;
                    mpdp_pkg::MODE_OFF:    n_res.drop_entries = 1'b0;
                    default:               n_res.drop_entries = short_mem;
                endcase
                n_entry_mode = mpdp_pkg::next_auto_mode(r_entry_mode, short_mem);

                // packet dropping; the automatic case needs the divider
                n_state = mpdp_pkg::ST_DONE;
                if (r_packet_mode == mpdp_pkg::MODE_FORCED) begin
                    n_res.drop_rate = r_manual_rate;
                end else if (r_packet_mode != mpdp_pkg::MODE_OFF && short_mem) begin
                    n_res.load_drop_counter = 1'b1;
                    n_rem   = '0;
                    n_quo   = r_threshold;
                    n_div   = r_threshold - r_avail;
                    n_cnt   = '0;
                    n_state = mpdp_pkg::ST_DIV;
                end
                n_packet_mode = mpdp_pkg::next_auto_mode(r_packet_mode, short_mem);

                // secure timeouts switch on crossing between levels 0-1 and 2-3
                n_secure_mode         = sec_next;
                n_res.timeout_change  = r_prev_secure[1] ^ sec_next[1];
                n_res.secure_timeouts = (r_prev_secure[1] ^ sec_next[1]) & sec_next[1];
                n_prev_secure         = sec_next;

                n_res.entry_mode_now  = n_entry_mode;
                n_res.packet_mode_now = n_packet_mode;
                n_res.secure_mode_now = sec_next;
            end

            mpdp_pkg::ST_DIV: begin
                if (!trial[mpdp_pkg::WordW]) begin
                    n_rem = trial[mpdp_pkg::WordW-1:0];
                    n_quo = {r_quo[mpdp_pkg::WordW-2:0], 1'b1};
                end else begin
                    n_rem = shifted[mpdp_pkg::WordW-1:0];
                    n_quo = {r_quo[mpdp_pkg::WordW-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == mpdp_pkg::DivCntW'(mpdp_pkg::WordW - 1)) begin
                    n_res.drop_rate = n_quo;
                    n_state         = mpdp_pkg::ST_DONE;
                end
            end

            mpdp_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_item  = r_res;
                    n_state     = mpdp_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = mpdp_pkg::ST_IDLE;
            end
        endcase

        // register writes; the user issues them only while no item is in flight, the block itself does not enforce this
        if (i_cfg_valid) begin
            case (i_cfg_index)
                mpdp_pkg::CFG_THRESHOLD:   n_threshold   = i_cfg_data;
                mpdp_pkg::CFG_MANUAL_RATE: n_manual_rate = i_cfg_data;
                mpdp_pkg::CFG_ENTRY_MODE:  n_entry_mode  = i_cfg_data[1:0];
                mpdp_pkg::CFG_PACKET_MODE: n_packet_mode = i_cfg_data[1:0];
                mpdp_pkg::CFG_SECURE_MODE: n_secure_mode = i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpdp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= mpdp_pkg::THRESHOLD_RST;
            r_manual_rate <= mpdp_pkg::MANUAL_RATE_RST;
            r_entry_mode  <= mpdp_pkg::MODE_OFF;
            r_packet_mode <= mpdp_pkg::MODE_OFF;
            r_secure_mode <= mpdp_pkg::MODE_OFF;
            r_prev_secure <= mpdp_pkg::MODE_OFF;
            r_out_valid   <= 1'b0;
        end else begin
            r_threshold   <= n_threshold;
            r_manual_rate <= n_manual_rate;
            r_entry_mode  <= n_entry_mode;
            r_packet_mode <= n_packet_mode;
            r_secure_mode <= n_secure_mode;
            r_prev_secure <= n_prev_secure;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_avail    <= n_avail;
        r_res      <= n_res;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_div      <= n_div;
        r_cnt      <= n_cnt;
        r_out_item <= n_out_item;
    end

endmodule

/* src/mpdp_checker.sv */
// Port-level checker of the memory pressure defense policy, bound to the top level.
`include "memory_pressure_defense_policy_defines.svh"

module mpdp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input mpdp_pkg::t_out_item o_out_item
);

    // an accepted sample blocks the input until its result is built
    `MPDP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a held result stays put
    `MPDP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

    // secure selection only comes with a timeout switch
    `MPDP_ASSERT_NOW(a_sel_needs_change, i_clk, i_rst_n, o_out_valid && !o_out_item.timeout_change, !o_out_item.secure_timeouts)

    // a counter reload only happens in short memory, which leaves packet mode high
    `MPDP_ASSERT_NOW(a_load_mode_high, i_clk, i_rst_n, o_out_valid && o_out_item.load_drop_counter, o_out_item.packet_mode_now == mpdp_pkg::MODE_AUTO_HIGH)

endmodule

bind memory_pressure_defense_policy mpdp_checker u_mpdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
